@@ sv/npc_pkg.sv @@
// Shared constants, codes and types of the nearest-speaker crossfade panner.
// No dependencies; every other file of the block imports this package.
package npc_pkg;

  // Table and speaker geometry
  localparam int ANGLE_STEPS  = 720;
  localparam int MAX_SPEAKERS = 16;
  localparam int ADDR_W       = $clog2(ANGLE_STEPS);

  // Field widths
  localparam int OP_W   = 1;
  localparam int TIDX_W = 10;
  localparam int SPK_W  = 4;
  localparam int AZ_W   = 16;
  localparam int SMP_W  = 24;
  localparam int GAIN_W = 17;

  // Q16 gain
  localparam int FRAC_W     = 16;
  localparam int FULL_GAIN  = 1 << FRAC_W;
  localparam int HALF_LSB   = 1 << (FRAC_W - 1);
  localparam int RAMP_RESET = 1024;

  // Request opcodes
  localparam logic [OP_W-1:0] OP_LOAD   = 1'b0;
  localparam logic [OP_W-1:0] OP_SAMPLE = 1'b1;

  // Queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Classified sample request, front to back
  typedef struct packed {
    logic [SPK_W-1:0]        spk;     // table speaker for the request's azimuth
    logic signed [SMP_W-1:0] sample;
    logic                    start;
  } npc_item_t;

endpackage

@@ sv/npc_if.sv @@
// Valid/ready channel interfaces of the panner: request in, mix result out.
// Depends on npc_pkg for field widths.
interface npc_in_if;
  import npc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic [TIDX_W-1:0]        table_index;
  logic [SPK_W-1:0]         table_speaker;
  logic signed [AZ_W-1:0]   azimuth;
  logic signed [SMP_W-1:0]  sample;
  logic                     chunk_start;

  modport source (output valid, op, table_index, table_speaker, azimuth, sample,
                  chunk_start, input ready);
  modport sink   (input valid, op, table_index, table_speaker, azimuth, sample,
                  chunk_start, output ready);
endinterface

interface npc_out_if;
  import npc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [SPK_W-1:0]         new_speaker;
  logic signed [SMP_W-1:0]  new_value;
  logic [SPK_W-1:0]         old_speaker;
  logic signed [SMP_W-1:0]  old_value;
  logic                     old_active;

  modport source (output valid, new_speaker, new_value, old_speaker, old_value,
                  old_active, input ready);
  modport sink   (input valid, new_speaker, new_value, old_speaker, old_value,
                  old_active, output ready);
endinterface

@@ sv/nearest_speaker_crossfade_panner.sv @@
// Top level of the nearest-speaker crossfade panner: front end, queue, back end.
// Depends on npc_pkg, npc_if, npc_front, npc_fifo and npc_back.
//
// Routes a mono sample stream to the nearest of up to 16 loudspeakers. Each
// request is either a table load (op = load: write one speaker number into one
// of 720 azimuth slots, no result) or an audio sample (one result). On a sample
// with chunk_start set, the azimuth is rounded to a slot (the slot past the last
// wraps to zero) and the speaker is read from the table; when it differs from
// the last chunk's speaker, a linear crossfade runs: the new speaker's gain
// starts at ramp_step and climbs by ramp_step per sample up to full scale (Q16),
// and the old speaker gets the complement, flagged by old_active, until the next
// chunk start. While in_ready is high the block takes one request per clock;
// while out_ready is high it delivers one result per clock. Each sample passes
// the index multiply, table read, queue, gain update and gain multiplies in
// that order. The table is a 720 x 4 single-port-write, registered-read
// memory with no reset and no clearing pass: every slot a chunk start can hit
// must be loaded first. The four-entry queue absorbs output back-pressure;
// in_ready drops when queued plus in-flight sample requests reach the depth.
// ramp_step resets to 1024; the user must write it through cfg_we/cfg_wdata
// only while the block is idle, which the block itself does not enforce.
module nearest_speaker_crossfade_panner (
  input  logic                        clk,
  input  logic                        rst_n,
  npc_in_if.sink                      in_ch,
  npc_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [npc_pkg::GAIN_W-1:0]  cfg_wdata
);
  import npc_pkg::*;

  logic [GAIN_W-1:0] ramp_step_r;
  logic              push, pop, head_valid;
  npc_item_t         push_item, head_item;
  logic [CNT_W-1:0]  fifo_cnt;

  // crossfade increment register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_step_r <= GAIN_W'(RAMP_RESET);
    end else if (cfg_we) begin
      ramp_step_r <= cfg_wdata;
    end
  end

  // accept, map azimuth, look up speaker
  npc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .fifo_cnt  (fifo_cnt),
    .push      (push),
    .push_item (push_item)
  );

  // decouples table lookup from output stalls
  npc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item),
    .cnt        (fifo_cnt)
  );

  // crossfade state and gain multiplies
  npc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .ramp_step  (ramp_step_r),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

@@ sv/npc_front.sv @@
// Front end: accepts requests, maps azimuth to a table slot, owns the speaker table.
// Depends on npc_pkg and npc_in_if; feeds sample requests to the queue.
module npc_front (
  input  logic                   clk,
  input  logic                   rst_n,
  npc_in_if.sink                 in_ch,
  input  logic [npc_pkg::CNT_W-1:0] fifo_cnt,
  output logic                   push,
  output npc_pkg::npc_item_t     push_item
);
  import npc_pkg::*;

  localparam int IDXP_W = AZ_W + $clog2(ANGLE_STEPS + 1) + 1;
  localparam int IDXR_W = IDXP_W - FRAC_W;

  typedef struct packed {
    logic                    load_ok;
    logic                    is_sample;
    logic [ADDR_W-1:0]       waddr;
    logic [ADDR_W-1:0]       raddr;
    logic [SPK_W-1:0]        spk;
    logic signed [SMP_W-1:0] sample;
    logic                    start;
  } npc_stage_t;

  logic              f1_v_r;
  npc_stage_t        f1_r;
  npc_stage_t        f1_nxt;
  logic              f2_v_r;
  logic signed [SMP_W-1:0] f2_sample_r;
  logic              f2_start_r;
  logic [SPK_W-1:0]  rd_r;
  logic [SPK_W-1:0]  mem [ANGLE_STEPS];

  logic              acc;
  logic [AZ_W-1:0]   az_u;
  logic [IDXP_W-1:0] idx_prod;
  logic [IDXR_W-1:0] idx_raw;
  logic [CNT_W:0]    pending;

  // Credit check: everything in flight must fit in the queue
  assign pending = {1'b0, fifo_cnt} + (CNT_W+1)'(f1_v_r && f1_r.is_sample)
                 + (CNT_W+1)'(f2_v_r);
  assign in_ch.ready = (int'(pending) < FIFO_DEPTH);
  assign acc = in_ch.valid && in_ch.ready;

  // azimuth + 32768 is the offset-binary form of the code
  assign az_u     = {~in_ch.azimuth[AZ_W-1], in_ch.azimuth[AZ_W-2:0]};
  assign idx_prod = IDXP_W'(az_u) * IDXP_W'(ANGLE_STEPS) + IDXP_W'(HALF_LSB);
  assign idx_raw  = idx_prod[IDXP_W-1:FRAC_W];

  always_comb begin
    f1_nxt.load_ok   = (in_ch.op == OP_LOAD) && (int'(in_ch.table_index) < ANGLE_STEPS)
                     && (int'(in_ch.table_speaker) < MAX_SPEAKERS);
    f1_nxt.is_sample = (in_ch.op == OP_SAMPLE);
    f1_nxt.waddr     = ADDR_W'(in_ch.table_index);
    // full-circle index wraps to slot zero
    f1_nxt.raddr     = (int'(idx_raw) >= ANGLE_STEPS) ? '0 : ADDR_W'(idx_raw);
    f1_nxt.spk       = in_ch.table_speaker;
    f1_nxt.sample    = in_ch.sample;
    f1_nxt.start     = in_ch.chunk_start;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else begin
      f1_v_r <= acc;
      f2_v_r <= f1_v_r && f1_r.is_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      f1_r <= f1_nxt;
    end
    f2_sample_r <= f1_r.sample;
    f2_start_r  <= f1_r.start;
  end

  // Speaker table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (f1_v_r && f1_r.load_ok) begin
      mem[f1_r.waddr] <= f1_r.spk;
    end
    rd_r <= mem[f1_r.raddr];
  end

  assign push             = f2_v_r;
  assign push_item.spk    = rd_r;
  assign push_item.sample = f2_sample_r;
  assign push_item.start  = f2_start_r;

endmodule

@@ sv/npc_fifo.sv @@
// Short request queue between the front end and the mixing back end.
// Depends on npc_pkg for the item type and depth.
module npc_fifo (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  npc_pkg::npc_item_t         push_item,
  input  logic                       pop,
  output logic                       head_valid,
  output npc_pkg::npc_item_t         head_item,
  output logic [npc_pkg::CNT_W-1:0]  cnt
);
  import npc_pkg::*;

  npc_item_t        slots_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wptr_r;
  logic [PTR_W-1:0] rptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_pop;

  assign do_pop     = pop && (cnt_r != '0);
  assign head_valid = (cnt_r != '0);
  assign head_item  = slots_r[rptr_r];
  assign cnt        = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= (int'(wptr_r) == FIFO_DEPTH - 1) ? '0 : wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= (int'(rptr_r) == FIFO_DEPTH - 1) ? '0 : rptr_r + 1'b1;
      end
      cnt_r <= cnt_r + CNT_W'(push) - CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wptr_r] <= push_item;
    end
  end

endmodule

@@ sv/npc_back.sv @@
// Back end: chunk/crossfade state, gain ramp, and the two gain multiplies.
// Depends on npc_pkg and npc_out_if; drains the request queue.
module npc_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [npc_pkg::GAIN_W-1:0]  ramp_step,
  input  logic                        head_valid,
  input  npc_pkg::npc_item_t          head_item,
  output logic                        pop,
  npc_out_if.source                   out_ch
);
  import npc_pkg::*;

  localparam int PROD_W = SMP_W + GAIN_W + 1;

  typedef struct packed {
    logic [SPK_W-1:0]        new_spk;
    logic [SPK_W-1:0]        old_spk;
    logic                    run;
    logic [GAIN_W-1:0]       gain;
    logic signed [SMP_W-1:0] sample;
  } npc_mix_t;

  // chunk state
  logic [SPK_W-1:0]  prev_r, prev_nxt;
  logic [SPK_W-1:0]  fade_r, fade_nxt;
  logic              run_r, run_nxt;
  logic [GAIN_W-1:0] gain_r, gain_nxt;

  logic              b1_v_r;
  npc_mix_t          b1_r, b1_nxt;
  logic              out_v_r;
  logic [SPK_W-1:0]  new_spk_r, old_spk_r;
  logic signed [SMP_W-1:0] new_val_r, old_val_r, new_val_nxt, old_val_nxt;
  logic              old_act_r;

  logic              adv2, load1;
  logic              differ;
  logic [GAIN_W-1:0] ramp_sat, cur_gain, old_gain;
  logic [GAIN_W:0]   gain_sum;
  logic signed [PROD_W-1:0] p_new, p_old;

  function automatic logic [GAIN_W-1:0] sat_gain(input logic [GAIN_W:0] g);
    return (int'(g) > FULL_GAIN) ? GAIN_W'(FULL_GAIN) : GAIN_W'(g);
  endfunction

  assign adv2  = !out_v_r || out_ch.ready;
  assign load1 = !b1_v_r || adv2;
  assign pop   = head_valid && load1;

  assign differ   = (head_item.spk != prev_r);
  assign ramp_sat = sat_gain({1'b0, ramp_step});

  always_comb begin
    prev_nxt = prev_r;
    fade_nxt = fade_r;
    run_nxt  = run_r;
    cur_gain = gain_r;
    if (head_item.start) begin
      prev_nxt = head_item.spk;
      run_nxt  = differ;
      if (differ) begin
        fade_nxt = prev_r;
        cur_gain = ramp_sat;
      end
    end
    gain_sum = {1'b0, cur_gain} + {1'b0, ramp_step};
    gain_nxt = run_nxt ? sat_gain(gain_sum) : cur_gain;

    b1_nxt.new_spk = prev_nxt;
    b1_nxt.old_spk = fade_nxt;
    b1_nxt.run     = run_nxt;
    b1_nxt.gain    = cur_gain;
    b1_nxt.sample  = head_item.sample;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      fade_r  <= '0;
      run_r   <= 1'b0;
      gain_r  <= '0;
      b1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (pop) begin
        prev_r <= prev_nxt;
        fade_r <= fade_nxt;
        run_r  <= run_nxt;
        gain_r <= gain_nxt;
      end
      if (load1) begin
        b1_v_r <= pop;
      end
      if (adv2) begin
        out_v_r <= b1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b1_r <= b1_nxt;
    end
  end

  // Q16 products, rounded half up
  assign old_gain = GAIN_W'(FULL_GAIN) - b1_r.gain;
  assign p_new = b1_r.sample * $signed({1'b0, b1_r.gain}) + PROD_W'(HALF_LSB);
  assign p_old = b1_r.sample * $signed({1'b0, old_gain}) + PROD_W'(HALF_LSB);

  always_comb begin
    if (b1_r.run) begin
      new_val_nxt = p_new[FRAC_W +: SMP_W];
      old_val_nxt = p_old[FRAC_W +: SMP_W];
    end else begin
      new_val_nxt = b1_r.sample;
      old_val_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && b1_v_r) begin
      new_spk_r <= b1_r.new_spk;
      old_spk_r <= b1_r.run ? b1_r.old_spk : '0;
      new_val_r <= new_val_nxt;
      old_val_r <= old_val_nxt;
      old_act_r <= b1_r.run;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.new_speaker = new_spk_r;
  assign out_ch.new_value   = new_val_r;
  assign out_ch.old_speaker = old_spk_r;
  assign out_ch.old_value   = old_val_r;
  assign out_ch.old_active  = old_act_r;

endmodule

@@ sv/npc_checker.sv @@
// Port-level checks for the panner, attached to the top level by bind.
// Depends on npc_pkg for field widths.
module npc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [npc_pkg::SPK_W-1:0]         new_speaker,
  input logic signed [npc_pkg::SMP_W-1:0]  new_value,
  input logic [npc_pkg::SPK_W-1:0]         old_speaker,
  input logic signed [npc_pkg::SMP_W-1:0]  old_value,
  input logic                              old_active
);
  import npc_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(new_speaker) && $stable(new_value)
      && $stable(old_speaker) && $stable(old_value) && $stable(old_active))
    else $error("result changed while stalled");

  // no crossfade means the fade-out fields are zero
  a_idle_old: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !old_active |-> old_speaker == '0 && old_value == '0)
    else $error("old fields nonzero without crossfade");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result present right after reset");

  a_rst_ready: assert property (@(posedge clk)
    $past(!rst_n) |-> in_ready)
    else $error("not ready right after reset");

endmodule

bind nearest_speaker_crossfade_panner npc_checker u_npc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .new_speaker (out_ch.new_speaker),
  .new_value   (out_ch.new_value),
  .old_speaker (out_ch.old_speaker),
  .old_value   (out_ch.old_value),
  .old_active  (out_ch.old_active)
);
